@@ sv/sqvs_pkg.sv @@
// Shared types, constants and tables for the sprite quad vertex setup block.
`timescale 1ns / 1ps

package sqvs_pkg;

   // angle resolution: low ANGLE_BITS bits of angle_turns are one full turn
   localparam int ANGLE_BITS   = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int CORDIC_W     = 34;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [31:0] ANGLE_MASK  = 32'((64'd1 << ANGLE_BITS) - 64'd1);
   localparam int          ANGLE_SHIFT = 32 - ANGLE_BITS;

   // restoring divider steps, one quotient bit per stage
   localparam int DIV_STEPS = 32;
   localparam int DIV_NUM_W = 35;
   localparam int DIV_DEN_W = 16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCREEN_WIDTH   = 3'd0,
      CSR_SCREEN_HEIGHT  = 3'd1,
      CSR_TEXTURE_ENABLE = 3'd2,
      CSR_TEXTURE_WIDTH  = 3'd3,
      CSR_TEXTURE_HEIGHT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] dest_x;
      logic signed [15:0] dest_y;
      logic signed [15:0] dest_w;
      logic signed [15:0] dest_h;
      logic [15:0]        src_x;
      logic [15:0]        src_y;
      logic [15:0]        src_w;
      logic [15:0]        src_h;
      logic [15:0]        angle_turns;
   } req_type;

   typedef struct packed {
      logic [1:0]         corner;
      logic signed [15:0] ndc_x;
      logic signed [15:0] ndc_y;
      logic [31:0]        tex_u;
      logic [31:0]        tex_v;
      logic               last;
   } rsp_type;

   // one sprite after trig setup, as held in the queue
   typedef struct packed {
      logic signed [15:0] sin_q;
      logic signed [15:0] cos_q;
      logic signed [17:0] cx2;
      logic signed [17:0] cy2;
      logic signed [15:0] dw;
      logic signed [15:0] dh;
      logic [15:0]        sx;
      logic [15:0]        sy;
      logic [15:0]        sw;
      logic [15:0]        sh;
   } sprite_type;

   // configuration as seen by the vertex datapath (zero sizes already made one)
   typedef struct packed {
      logic [13:0] w_eff;
      logic [13:0] h_eff;
      logic [15:0] w4;
      logic [15:0] h4;
      logic [30:0] xbias;
      logic [30:0] ybias;
      logic        tex_en;
      logic [13:0] tw_eff;
      logic [13:0] th_eff;
   } cfg_type;

   function automatic logic signed [CORDIC_W-1:0] atan_step(input int i);
      logic signed [CORDIC_W-1:0] r;
      case (i)
         0:       r = 34'sd536870912;
         1:       r = 34'sd316933406;
         2:       r = 34'sd167458907;
         3:       r = 34'sd85004756;
         4:       r = 34'sd42667331;
         5:       r = 34'sd21354465;
         6:       r = 34'sd10679838;
         7:       r = 34'sd5340245;
         8:       r = 34'sd2670163;
         9:       r = 34'sd1335087;
         10:      r = 34'sd667544;
         11:      r = 34'sd333772;
         12:      r = 34'sd166886;
         13:      r = 34'sd83443;
         14:      r = 34'sd41722;
         15:      r = 34'sd20861;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ sv/sqvs_front.sv @@
// Front end: sprite intake and pipelined CORDIC sine/cosine.
`timescale 1ns / 1ps

module sqvs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sqvs_pkg::req_type   req_data,
   output logic                push_valid,
   input  logic                push_ready,
   output sqvs_pkg::sprite_type push_data
);
   import sqvs_pkg::*;

   typedef struct packed {
      logic [1:0]         quad;
      logic signed [17:0] cx2;
      logic signed [17:0] cy2;
      logic signed [15:0] dw;
      logic signed [15:0] dh;
      logic [15:0]        sx;
      logic [15:0]        sy;
      logic [15:0]        sw;
      logic [15:0]        sh;
   } front_sb_type;

   localparam int LAST = CORDIC_STEPS - 1;

   logic                        en;
   logic [CORDIC_STEPS-1:0]     vld_ff;
   logic signed [CORDIC_W-1:0]  x_ff [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0]  y_ff [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0]  z_ff [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0]  x_in [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0]  y_in [CORDIC_STEPS];
   logic signed [CORDIC_W-1:0]  z_in [CORDIC_STEPS];
   front_sb_type                sb_ff [CORDIC_STEPS];
   front_sb_type                sb_in;
   logic [31:0]                 angle;
   logic signed [CORDIC_W-1:0]  cx, sy;

   // stall only when a finished sprite cannot enter the queue
   assign en        = !(vld_ff[LAST] && !push_ready);
   assign req_ready = en;
   assign push_valid = vld_ff[LAST];

   assign angle = ({16'b0, req_data.angle_turns} & ANGLE_MASK) << ANGLE_SHIFT;

   always_comb begin
      sb_in.quad = angle[31:30];
      sb_in.cx2  = (18'(req_data.dest_x) <<< 1) + 18'(req_data.dest_w);
      sb_in.cy2  = (18'(req_data.dest_y) <<< 1) + 18'(req_data.dest_h);
      sb_in.dw   = req_data.dest_w;
      sb_in.dh   = req_data.dest_h;
      sb_in.sx   = req_data.src_x;
      sb_in.sy   = req_data.src_y;
      sb_in.sw   = req_data.src_w;
      sb_in.sh   = req_data.src_h;
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CORDIC_W-1:0] xi, yi, zi;
      if (i == 0) begin : g_first
         assign xi = CORDIC_GAIN;
         assign yi = '0;
         assign zi = $signed({4'b0, angle[29:0]});
      end else begin : g_next
         assign xi = x_ff[i-1];
         assign yi = y_ff[i-1];
         assign zi = z_ff[i-1];
      end

      always_comb begin
         if (!zi[CORDIC_W-1]) begin
            x_in[i] = xi - (yi >>> i);
            y_in[i] = yi + (xi >>> i);
            z_in[i] = zi - atan_step(i);
         end else begin
            x_in[i] = xi + (yi >>> i);
            y_in[i] = yi - (xi >>> i);
            z_in[i] = zi + atan_step(i);
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
            sb_ff[i] <= (i == 0) ? sb_in : sb_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[CORDIC_STEPS-2:0], req_valid};
      end
   end

   function automatic logic signed [15:0] to_q15(input logic signed [CORDIC_W-1:0] v);
      logic signed [CORDIC_W:0] t;
      logic signed [CORDIC_W:0] r;
      t = (CORDIC_W+1)'(v) + 35'sd16384;
      r = t >>> 15;
      if (r > 35'sd32767) return 16'sh7fff;
      if (r < -35'sd32768) return 16'sh8000;
      return 16'(r);
   endfunction

   // quadrant fold
   always_comb begin
      case (sb_ff[LAST].quad)
         2'd0: begin
            cx = x_ff[LAST];
            sy = y_ff[LAST];
         end
         2'd1: begin
            cx = -y_ff[LAST];
            sy = x_ff[LAST];
         end
         2'd2: begin
            cx = -x_ff[LAST];
            sy = -y_ff[LAST];
         end
         default: begin
            cx = y_ff[LAST];
            sy = -x_ff[LAST];
         end
      endcase
      push_data.sin_q = to_q15(sy);
      push_data.cos_q = to_q15(cx);
      push_data.cx2   = sb_ff[LAST].cx2;
      push_data.cy2   = sb_ff[LAST].cy2;
      push_data.dw    = sb_ff[LAST].dw;
      push_data.dh    = sb_ff[LAST].dh;
      push_data.sx    = sb_ff[LAST].sx;
      push_data.sy    = sb_ff[LAST].sy;
      push_data.sw    = sb_ff[LAST].sw;
      push_data.sh    = sb_ff[LAST].sh;
   end

endmodule

@@ sv/sqvs_queue.sv @@
// Sprite queue between front end and vertex datapath.
`timescale 1ns / 1ps

module sqvs_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sqvs_pkg::sprite_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output sqvs_pkg::sprite_type head_data
);
   import sqvs_pkg::*;

   sprite_type            mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff;

   assign full       = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

@@ sv/sqvs_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps

module sqvs_div (
   input  logic                           clock,
   input  logic                           en,
   input  logic [sqvs_pkg::DIV_NUM_W-1:0] num,
   input  logic [sqvs_pkg::DIV_DEN_W-1:0] den,
   output logic [sqvs_pkg::DIV_STEPS-1:0] quo
);
   import sqvs_pkg::*;

   // remainder stays below den; low bits of numerator shift out as quotient shifts in
   logic [DIV_DEN_W-1:0] rem_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] nq_ff  [DIV_STEPS];
   logic [DIV_DEN_W-1:0] rem_in [DIV_STEPS];
   logic [DIV_STEPS-1:0] nq_in  [DIV_STEPS];

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_stage
      logic [DIV_DEN_W-1:0] ri;
      logic [DIV_STEPS-1:0] qi;
      logic [DIV_DEN_W:0]   t;
      logic                 ge;
      if (i == 0) begin : g_first
         assign ri = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_STEPS]);
         assign qi = num[DIV_STEPS-1:0];
      end else begin : g_next
         assign ri = rem_ff[i-1];
         assign qi = nq_ff[i-1];
      end
      assign t  = {ri, qi[DIV_STEPS-1]};
      assign ge = (t >= {1'b0, den});
      assign rem_in[i] = ge ? DIV_DEN_W'(t - {1'b0, den}) : DIV_DEN_W'(t);
      assign nq_in[i]  = {qi[DIV_STEPS-2:0], ge};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in[i];
            nq_ff[i]  <= nq_in[i];
         end
      end
   end

   assign quo = nq_ff[DIV_STEPS-1];

endmodule

@@ sv/sqvs_back.sv @@
// Back end: corner sequencer, rotation, device and texture mapping, result register.
`timescale 1ns / 1ps

module sqvs_back (
   input  logic                 clock,
   input  logic                 reset,
   input  sqvs_pkg::cfg_type    cfg,
   input  logic                 head_valid,
   input  sqvs_pkg::sprite_type head_data,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sqvs_pkg::rsp_type    rsp_data
);
   import sqvs_pkg::*;

   typedef struct packed {
      logic [1:0]         k;
      logic signed [16:0] ox;
      logic signed [16:0] oy;
      logic signed [15:0] c;
      logic signed [15:0] s;
      logic signed [17:0] cx2;
      logic signed [17:0] cy2;
      logic [16:0]        tu;
      logic [16:0]        tv;
   } vtx_type;

   typedef struct packed {
      logic [1:0]         k;
      logic signed [32:0] cxs;
      logic signed [32:0] cys;
      logic signed [32:0] oxc;
      logic signed [32:0] oys;
      logic signed [32:0] oxs;
      logic signed [32:0] oyc;
      logic [16:0]        tu;
      logic [16:0]        tv;
   } mul_type;

   typedef struct packed {
      logic [1:0]         k;
      logic signed [35:0] mx;
      logic signed [35:0] my;
      logic [16:0]        tu;
      logic [16:0]        tv;
   } sum_type;

   typedef struct packed {
      logic [1:0]  k;
      logic        x_lo;
      logic        x_hi;
      logic        y_lo;
      logic        y_hi;
      logic        u_sat;
      logic        v_sat;
      logic [16:0] tu;
      logic [16:0] tv;
   } side_type;

   localparam int LAST = DIV_STEPS - 1;

   logic                 en;
   logic [1:0]           k_ff;
   logic                 v_vld_ff, m_vld_ff, p_vld_ff;
   vtx_type              v_ff, v_in;
   mul_type              m_ff, m_in;
   sum_type              p_ff, p_in;
   side_type             sd_in;
   side_type             sd_ff [DIV_STEPS];
   logic [DIV_STEPS-1:0] sdv_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff, rsp_in;
   logic [DIV_NUM_W-1:0] num_x, num_y, num_u, num_v;
   logic [31:0]          q_x, q_y, q_u, q_v;
   logic [15:0]          tu_den, tv_den;

   // whole datapath advances together; the result register parts it from the sink
   assign en        = !rsp_valid_ff || rsp_ready;
   assign pop       = en && head_valid && (k_ff == 2'd3);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      v_in.k   = k_ff;
      v_in.ox  = k_ff[0] ? 17'(head_data.dw) : -17'(head_data.dw);
      v_in.oy  = k_ff[1] ? 17'(head_data.dh) : -17'(head_data.dh);
      v_in.c   = head_data.cos_q;
      v_in.s   = head_data.sin_q;
      v_in.cx2 = head_data.cx2;
      v_in.cy2 = head_data.cy2;
      v_in.tu  = k_ff[0] ? 17'(head_data.sx) + 17'(head_data.sw) : 17'(head_data.sx);
      v_in.tv  = k_ff[1] ? 17'(head_data.sy) + 17'(head_data.sh) : 17'(head_data.sy);
   end

   always_comb begin
      m_in.k   = v_ff.k;
      m_in.cxs = 33'(v_ff.cx2) <<< 15;
      m_in.cys = 33'(v_ff.cy2) <<< 15;
      m_in.oxc = v_ff.ox * v_ff.c;
      m_in.oys = v_ff.oy * v_ff.s;
      m_in.oxs = v_ff.ox * v_ff.s;
      m_in.oyc = v_ff.oy * v_ff.c;
      m_in.tu  = v_ff.tu;
      m_in.tv  = v_ff.tv;
   end

   // bias folds in the half-divisor rounding and shifts the quotient to [0, 65535]
   always_comb begin
      p_in.k  = m_ff.k;
      p_in.mx = 36'(m_ff.cxs) + 36'(m_ff.oxc) - 36'(m_ff.oys) + $signed({5'b0, cfg.xbias});
      p_in.my = 36'(m_ff.cys) + 36'(m_ff.oxs) + 36'(m_ff.oyc) + $signed({5'b0, cfg.ybias});
      p_in.tu = m_ff.tu;
      p_in.tv = m_ff.tv;
   end

   assign tu_den = {1'b0, cfg.tw_eff, 1'b0};
   assign tv_den = {1'b0, cfg.th_eff, 1'b0};

   always_comb begin
      num_x = {3'b0, p_ff.mx[31:0]};
      num_y = {3'b0, p_ff.my[31:0]};
      num_u = {p_ff.tu, 17'b0} + DIV_NUM_W'(cfg.tw_eff);
      num_v = {p_ff.tv, 17'b0} + DIV_NUM_W'(cfg.th_eff);
      sd_in.k     = p_ff.k;
      sd_in.x_lo  = p_ff.mx[35];
      sd_in.x_hi  = !p_ff.mx[35] && (p_ff.mx[34:18] >= {3'b0, cfg.w_eff});
      sd_in.y_lo  = p_ff.my[35];
      sd_in.y_hi  = !p_ff.my[35] && (p_ff.my[34:18] >= {3'b0, cfg.h_eff});
      // quotient reaches 2^32 exactly when numerator >= size << 33
      sd_in.u_sat = ({12'b0, num_u[34:33]} >= cfg.tw_eff);
      sd_in.v_sat = ({12'b0, num_v[34:33]} >= cfg.th_eff);
      sd_in.tu    = p_ff.tu;
      sd_in.tv    = p_ff.tv;
   end

   sqvs_div u_div_x (.clock(clock), .en(en), .num(num_x), .den(cfg.w4),  .quo(q_x));
   sqvs_div u_div_y (.clock(clock), .en(en), .num(num_y), .den(cfg.h4),  .quo(q_y));
   sqvs_div u_div_u (.clock(clock), .en(en), .num(num_u), .den(tu_den), .quo(q_u));
   sqvs_div u_div_v (.clock(clock), .en(en), .num(num_v), .den(tv_den), .quo(q_v));

   always_comb begin
      side_type sd;
      sd = sd_ff[LAST];
      rsp_in.corner = sd.k;
      rsp_in.last   = (sd.k == 2'd3);
      if (sd.x_lo)      rsp_in.ndc_x = 16'sh8000;
      else if (sd.x_hi) rsp_in.ndc_x = 16'sh7fff;
      else              rsp_in.ndc_x = {~q_x[15], q_x[14:0]};
      if (sd.y_lo)      rsp_in.ndc_y = 16'sh7fff;
      else if (sd.y_hi) rsp_in.ndc_y = 16'sh8000;
      else              rsp_in.ndc_y = {q_y[15], ~q_y[14:0]};
      if (cfg.tex_en) begin
         rsp_in.tex_u = sd.u_sat ? '1 : q_u;
         rsp_in.tex_v = sd.v_sat ? '1 : q_v;
      end else begin
         rsp_in.tex_u = sd.tu[16] ? '1 : {sd.tu[15:0], 16'b0};
         rsp_in.tex_v = sd.tv[16] ? '1 : {sd.tv[15:0], 16'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff     <= v_in;
         m_ff     <= m_in;
         p_ff     <= p_in;
         sd_ff[0] <= sd_in;
         for (int i = 1; i < DIV_STEPS; i++) sd_ff[i] <= sd_ff[i-1];
         rsp_ff   <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         v_vld_ff     <= 1'b0;
         m_vld_ff     <= 1'b0;
         p_vld_ff     <= 1'b0;
         sdv_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         if (head_valid) k_ff <= k_ff + 2'd1;
         v_vld_ff     <= head_valid;
         m_vld_ff     <= v_vld_ff;
         p_vld_ff     <= m_vld_ff;
         sdv_ff       <= {sdv_ff[DIV_STEPS-2:0], p_vld_ff};
         rsp_valid_ff <= sdv_ff[LAST];
      end
   end

endmodule

@@ sv/sprite_quad_vertex_setup_core.sv @@
// Top level of the rotated sprite quad vertex setup block.
// A sprite passes the CORDIC stages, the queue, the vertex, multiply and sum registers,
// the divider stages and the result register before its first vertex beat.
// Throughput: one vertex beat per cycle while rsp_ready holds; the back end's corner
// sequencer gives four beats per sprite. The front end takes a sprite per cycle until
// the 4-entry queue is full and a finished sprite waits at the end of the 16-stage CORDIC.
// Reset (synchronous): config returns to defaults, pipeline valids and queue clear.
`timescale 1ns / 1ps

module sprite_quad_vertex_setup_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sqvs_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output sqvs_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sqvs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sqvs_pkg::CSR_DATA_W-1:0] csr_data
);
   import sqvs_pkg::*;

   localparam logic [16:0] XBIAS_MUL = 17'd98306;  // 2 + 24576 * 4
   localparam logic [16:0] YBIAS_MUL = 17'd98302;  // 2 + 24575 * 4

   // config registers
   logic [13:0] scr_w_ff, scr_h_ff, tex_w_ff, tex_h_ff;
   logic        tex_en_ff;
   logic [13:0] w_eff, h_eff;
   cfg_type     cfg_ff, cfg_in;

   // front/queue/back hookup
   logic        push_valid, push_ready, q_full, head_valid, pop;
   sprite_type  push_data, head_data;

   // writes are always accepted; csr_ready is tied high
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff  <= 14'd1280;
         scr_h_ff  <= 14'd720;
         tex_en_ff <= 1'b0;
         tex_w_ff  <= 14'd1;
         tex_h_ff  <= 14'd1;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:   scr_w_ff  <= csr_data;
            CSR_SCREEN_HEIGHT:  scr_h_ff  <= csr_data;
            CSR_TEXTURE_ENABLE: tex_en_ff <= csr_data[0];
            CSR_TEXTURE_WIDTH:  tex_w_ff  <= csr_data;
            CSR_TEXTURE_HEIGHT: tex_h_ff  <= csr_data;
            default: ;  // unknown index: dropped
         endcase
      end
   end

   // zero size behaves as one
   assign w_eff = (scr_w_ff == '0) ? 14'd1 : scr_w_ff;
   assign h_eff = (scr_h_ff == '0) ? 14'd1 : scr_h_ff;

   // derived terms registered; the user must change config only while the block is idle, the block does not enforce it
   always_comb begin
      cfg_in.w_eff  = w_eff;
      cfg_in.h_eff  = h_eff;
      cfg_in.w4     = {w_eff, 2'b0};
      cfg_in.h4     = {h_eff, 2'b0};
      cfg_in.xbias  = {17'b0, w_eff} * {14'b0, XBIAS_MUL};
      cfg_in.ybias  = {17'b0, h_eff} * {14'b0, YBIAS_MUL};
      cfg_in.tex_en = tex_en_ff;
      cfg_in.tw_eff = (tex_w_ff == '0) ? 14'd1 : tex_w_ff;
      cfg_in.th_eff = (tex_h_ff == '0) ? 14'd1 : tex_h_ff;
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign push_ready = !q_full;

   // front: 16-stage CORDIC, stalls only when the queue is full and a finished sprite waits at its end
   sqvs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   sqvs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid && push_ready),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // back: corner sequencer, multiply, bias, 32-stage dividers, result register
   sqvs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

@@ sv/sqvs_checker.sv @@
// Port-level checks for the sprite quad vertex setup block, bound to the top level.
`timescale 1ns / 1ps

module sqvs_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sqvs_pkg::rsp_type rsp_data
);

   logic [1:0] exp_corner_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_corner_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         exp_corner_ff <= exp_corner_ff + 2'd1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.corner == exp_corner_ff)
      else $error("corner out of strip order");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.last == (rsp_data.corner == 2'd3))
      else $error("last flag not on fourth vertex");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind sprite_quad_vertex_setup_core sqvs_checker u_sqvs_checker (.*);
